FILE: hdl/ucte_pkg.sv
// ----------------------------------------------------------------------------
// ucte_pkg - shared types and constants for the calendar to epoch converter
// Widths of the pipeline words, the normalized date word and the table of
// days before each month in a non-leap year.
// ----------------------------------------------------------------------------
package ucte_pkg;

    localparam int YEAR_W  = 12;  // signed normalized year, -11..1033
    localparam int MON_W   = 4;   // normalized month, 0..11
    localparam int MDAY_W  = 10;  // signed day offset in year, -1..364
    localparam int YDAY_W  = 21;  // signed 365 * (year - 70)
    localparam int LEAP_W  = 12;  // signed leap day correction
    localparam int DAYS_W  = 21;
    localparam int HOURS_W = 26;
    localparam int MINS_W  = 32;
    localparam int SECS_W  = 38;
    localparam int OUT_W   = 36;

    typedef struct packed {
        logic signed [YEAR_W-1:0] year;
        logic        [MON_W-1:0]  month;
        logic signed [YEAR_W-1:0] feb_year;
    } norm_t;

    function automatic logic [8:0] days_before_month(input logic [MON_W-1:0] m);
        logic [8:0] d;
        case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

FILE: hdl/utc_calendar_to_epoch_seconds_core.sv
// Throughput: one word per cycle; each stage holds only while the one after
// it is full and stalled, so bubbles close up under backpressure.
// Reset: synchronous, active low; clears the stage valid bits only.
// Stages: month fold, leap divisions, day sum, x24, x60, x60 and clamp.
// ----------------------------------------------------------------------------
// utc_calendar_to_epoch_seconds_core - broken-down UTC time to epoch seconds
// Six-stage pipeline; totals below zero come out as -1.
// ----------------------------------------------------------------------------
module utc_calendar_to_epoch_seconds_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [5:0]                        s_second,
    input  logic [5:0]                        s_minute,
    input  logic [4:0]                        s_hour,
    input  logic [4:0]                        s_day_of_month,
    input  logic signed [7:0]                 s_month_index,
    input  logic [9:0]                        s_years_since_1900,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [ucte_pkg::OUT_W-1:0] m_epoch_seconds
);
    import ucte_pkg::*;

    localparam int NSTG = 6;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] stg_rdy;

    // stage payload registers
    norm_t                    norm_next;
    norm_t                    norm_reg;
    logic [5:0]               sec_reg   [NSTG-1];
    logic [5:0]               min_reg   [NSTG-2];
    logic [4:0]               hr_reg    [NSTG-3];
    logic [4:0]               mday_reg;
    logic signed [MDAY_W-1:0] md_reg;
    logic signed [MDAY_W-1:0] md_next;
    logic signed [YDAY_W-1:0] yd_reg;
    logic signed [YDAY_W-1:0] yd_next;
    logic signed [LEAP_W-1:0] leap_reg;
    logic signed [LEAP_W-1:0] leap_next;
    logic signed [DAYS_W-1:0] days_reg;
    logic signed [DAYS_W-1:0] days_next;
    logic signed [HOURS_W-1:0] hours_reg;
    logic signed [HOURS_W-1:0] hours_next;
    logic signed [MINS_W-1:0] mins_reg;
    logic signed [MINS_W-1:0] mins_next;
    logic signed [OUT_W-1:0]  out_reg;
    logic signed [OUT_W-1:0]  out_next;

    // leap correction terms
    logic signed [YEAR_W-1:0] div4_arg;
    logic signed [YEAR_W-1:0] div100_arg;
    logic [YEAR_W-1:0]        div400_arg;
    logic [YEAR_W-1:0]        abs4;
    logic [YEAR_W-1:0]        abs100;
    logic [22:0]              prod100;
    logic [22:0]              prod400;
    logic signed [YEAR_W-1:0] q4;
    logic signed [YEAR_W-1:0] q100;
    logic signed [YEAR_W-1:0] q400;
    logic signed [YEAR_W-1:0] yoff;
    logic signed [SECS_W-1:0] secs;

    ucte_month_norm u_norm (
        .month_index      (s_month_index),
        .years_since_1900 (s_years_since_1900),
        .norm             (norm_next)
    );

    // ready ripples back from the output; a stage advances when it is empty
    // or the stage after it advances
    always_comb begin
        stg_rdy[NSTG-1] = !vld_reg[NSTG-1] || m_ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            stg_rdy[i] = !vld_reg[i] || stg_rdy[i+1];
        end
        vld_next = vld_reg;
        if (stg_rdy[0]) begin
            vld_next[0] = s_valid;
        end
        for (int i = 1; i < NSTG; i++) begin
            if (stg_rdy[i]) begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    assign s_ready         = stg_rdy[0];
    assign m_valid         = vld_reg[NSTG-1];
    assign m_epoch_seconds = out_reg;

    // stage 2: truncating divisions by 4, 100 and 400 plus the year and day terms
    always_comb begin
        div4_arg   = norm_reg.feb_year - YEAR_W'(69);
        div100_arg = norm_reg.feb_year - YEAR_W'(1);
        div400_arg = YEAR_W'(norm_reg.feb_year + YEAR_W'(299));
        abs4       = div4_arg[YEAR_W-1] ? YEAR_W'(-div4_arg) : YEAR_W'(div4_arg);
        abs100     = div100_arg[YEAR_W-1] ? YEAR_W'(-div100_arg) : YEAR_W'(div100_arg);
        // x / 100 as x * 1311 >> 17, x / 400 as x * 1311 >> 19
        prod100    = 23'(abs100) * 23'd1311;
        prod400    = 23'(div400_arg) * 23'd1311;
        q4         = div4_arg[YEAR_W-1] ? -YEAR_W'(abs4 >> 2) : YEAR_W'(abs4 >> 2);
        q100       = div100_arg[YEAR_W-1] ? -YEAR_W'(prod100[22:17])
                                          : YEAR_W'(prod100[22:17]);
        q400       = YEAR_W'(prod400[22:19]);
        leap_next  = q4 - q100 + q400;
        yoff       = norm_reg.year - YEAR_W'(70);
        yd_next    = YDAY_W'(yoff) * YDAY_W'(365);
        md_next    = MDAY_W'(days_before_month(norm_reg.month))
                   + MDAY_W'(mday_reg) - MDAY_W'(1);
    end

    always_comb begin
        days_next  = yd_reg + DAYS_W'(leap_reg) + DAYS_W'(md_reg);
        hours_next = HOURS_W'(days_reg) * HOURS_W'(24) + HOURS_W'(hr_reg[2]);
        mins_next  = MINS_W'(hours_reg) * MINS_W'(60) + MINS_W'(min_reg[3]);
        secs       = SECS_W'(mins_reg) * SECS_W'(60) + SECS_W'(sec_reg[4]);
        // clamp anything before the epoch to -1
        out_next   = secs[SECS_W-1] ? '1 : secs[OUT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_rdy[0]) begin
            norm_reg   <= norm_next;
            mday_reg   <= s_day_of_month;
            sec_reg[0] <= s_second;
            min_reg[0] <= s_minute;
            hr_reg[0]  <= s_hour;
        end
        if (stg_rdy[1]) begin
            md_reg     <= md_next;
            yd_reg     <= yd_next;
            leap_reg   <= leap_next;
            sec_reg[1] <= sec_reg[0];
            min_reg[1] <= min_reg[0];
            hr_reg[1]  <= hr_reg[0];
        end
        if (stg_rdy[2]) begin
            days_reg   <= days_next;
            sec_reg[2] <= sec_reg[1];
            min_reg[2] <= min_reg[1];
            hr_reg[2]  <= hr_reg[1];
        end
        if (stg_rdy[3]) begin
            hours_reg  <= hours_next;
            sec_reg[3] <= sec_reg[2];
            min_reg[3] <= min_reg[2];
        end
        if (stg_rdy[4]) begin
            mins_reg   <= mins_next;
            sec_reg[4] <= sec_reg[3];
        end
        if (stg_rdy[5]) begin
            out_reg    <= out_next;
        end
    end

endmodule

FILE: hdl/ucte_month_norm.sv
// ----------------------------------------------------------------------------
// ucte_month_norm - month normalization
// Folds a signed month into 0..11 with truncating division by twelve,
// carries whole years into the year and derives the February year.
// ----------------------------------------------------------------------------
module ucte_month_norm (
    input  logic signed [7:0]  month_index,
    input  logic        [9:0]  years_since_1900,
    output ucte_pkg::norm_t    norm
);
    import ucte_pkg::*;

    logic [7:0]               mon_abs;
    logic [14:0]              quot_prod;
    logic [3:0]               quot_abs;
    logic [3:0]               rem_abs;
    logic [7:0]               twelve_q;
    logic signed [YEAR_W-1:0] carry;
    logic [MON_W-1:0]         month;
    logic signed [YEAR_W-1:0] year;

    always_comb begin
        mon_abs   = month_index[7] ? 8'(-month_index) : 8'(month_index);
        // x / 12 as x * 171 >> 11, exact for x up to 128
        quot_prod = 15'(mon_abs) * 15'd171;
        quot_abs  = quot_prod[14:11];
        twelve_q  = 8'(quot_abs) * 8'd12;
        rem_abs   = 4'(mon_abs - twelve_q);
        if (!month_index[7]) begin
            month = rem_abs;
            carry = YEAR_W'(quot_abs);
        end else if (rem_abs == 4'd0) begin
            month = 4'd0;
            carry = -YEAR_W'(quot_abs);
        end else begin
            // borrow one year for a negative remainder
            month = 4'd12 - rem_abs;
            carry = -YEAR_W'(quot_abs) - YEAR_W'(1);
        end
        year          = YEAR_W'(years_since_1900) + carry;
        norm.year     = year;
        norm.month    = month;
        norm.feb_year = (month > 4'd1) ? year + YEAR_W'(1) : year;
    end

endmodule

FILE: hdl/ucte_checker.sv
// ----------------------------------------------------------------------------
// ucte_checker - port level checks for the epoch seconds converter
// Watches the result channel and the backpressure path.
// ----------------------------------------------------------------------------
module ucte_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [ucte_pkg::OUT_W-1:0] m_epoch_seconds
);
    import ucte_pkg::*;

    // hold a stalled result word
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_epoch_seconds))
        else $error("result word changed while stalled");

    // the only negative result is -1
    a_neg_is_minus_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_epoch_seconds[OUT_W-1] |-> (&m_epoch_seconds))
        else $error("negative result other than -1");

    // a draining output never blocks the input
    a_no_false_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output drains");

endmodule

bind utc_calendar_to_epoch_seconds_core ucte_checker u_ucte_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_epoch_seconds (m_epoch_seconds)
);
